@@ rtl/rau_pkg.sv @@
// shared types and constants for the rational arithmetic unit
`default_nettype none
package rau_pkg;
    localparam logic [2:0] OP_ADD  = 3'd0;
    localparam logic [2:0] OP_SUB  = 3'd1;
    localparam logic [2:0] OP_MUL  = 3'd2;
    localparam logic [2:0] OP_DIV  = 3'd3;
    localparam logic [2:0] OP_CMP  = 3'd4;
    localparam logic [2:0] OP_RED  = 3'd5;
    localparam logic [2:0] OP_ZERO = 3'd6;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZDIV = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    localparam logic [1:0] CMP_GT = 2'b01;
    localparam logic [1:0] CMP_EQ = 2'b00;
    localparam logic [1:0] CMP_LT = 2'b11;

    typedef logic [63:0] t_dword;
    typedef logic [64:0] t_num;
endpackage
`default_nettype wire

@@ rtl/rational_arithmetic_unit.sv @@
// rational arithmetic unit with gcd reduction on a shared multiplier and divider
// compare, zero test and unused codes finish without a division, as does a zero divisor with ST_ZDIV
// other ops run one division per euclid step, then divide numerator and denominator by the gcd
// throughput: one transaction at a time, o_ready low from accept until the result is taken
// the shared units are one 32x32 multiplier and one bit-serial restoring divider
// reset: synchronous active-low i_rst_n clears the sequencer and output valid
`default_nettype none
module rational_arithmetic_unit #(
    parameter int WORD_BITS = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [2:0]  i_operation,
    input  wire         i_a_sign,
    input  wire  [31:0] i_a_numerator,
    input  wire  [31:0] i_a_denominator,
    input  wire         i_b_sign,
    input  wire  [31:0] i_b_numerator,
    input  wire  [31:0] i_b_denominator,
    output logic        o_valid,
    input  wire         i_ready,
    output logic        o_result_sign,
    output logic [31:0] o_result_numerator,
    output logic [31:0] o_result_denominator,
    output logic [1:0]  o_compare_result,
    output logic        o_is_zero,
    output logic [1:0]  o_status
);
    import rau_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL1 = 4'd1;
    localparam logic [3:0] S_MUL2 = 4'd2;
    localparam logic [3:0] S_MUL3 = 4'd3;
    localparam logic [3:0] S_FORM = 4'd4;
    localparam logic [3:0] S_DIV1 = 4'd5;
    localparam logic [3:0] S_GCD  = 4'd6;
    localparam logic [3:0] S_DIV2 = 4'd7;
    localparam logic [3:0] S_DIV3 = 4'd8;
    localparam logic [3:0] S_FIN  = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd10;
    localparam logic [3:0] S_DSET = 4'd11;

    localparam logic [1:0] P_REM    = 2'd0;
    localparam logic [1:0] P_EUCLID = 2'd1;
    localparam logic [1:0] P_NUM    = 2'd2;
    localparam logic [1:0] P_DEN    = 2'd3;

    localparam t_dword LIM = t_dword'((65'd1 << WORD_BITS) - 65'd1);

    logic [3:0]  r_state;
    logic [2:0]  r_op;
    logic        r_as, r_bs;
    logic [31:0] r_an, r_ad, r_bn, r_bd;
    t_dword      r_p, r_q, r_d;
    logic        r_sign;
    t_num        r_n;
    // shared multiplier
    logic [31:0] r_ma, r_mb;
    t_dword      w_prod;
    // shared divider
    t_num        r_dvd;
    t_dword      r_dvs, r_rem;
    t_num        r_quo;
    logic [6:0]  r_cnt;
    t_dword      r_gx, r_gy;
    t_num        r_numq;
    logic [1:0]  r_sel;

    logic        r_res_sign;
    logic [31:0] r_res_num, r_res_den;
    logic [1:0]  r_cmp, r_st;
    logic        r_zero;

    assign w_prod = t_dword'(r_ma) * t_dword'(r_mb);

    logic   w_top;
    t_dword w_sh, w_sub;
    logic   w_ge;
    always_comb begin
        w_top = r_rem[63];
        w_sh  = {r_rem[62:0], r_dvd[64]};
        w_ge  = w_top || (w_sh >= r_dvs);
        w_sub = w_sh - r_dvs;
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_result_sign = r_res_sign;
    assign o_result_numerator = r_res_num;
    assign o_result_denominator = r_res_den;
    assign o_compare_result = r_cmp;
    assign o_is_zero = r_zero;
    assign o_status = r_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_op <= i_operation;
                        r_as <= i_a_sign;
                        r_an <= i_a_numerator;
                        r_ad <= i_a_denominator;
                        r_bs <= (i_operation == OP_SUB) ? ~i_b_sign : i_b_sign;
                        r_bn <= (i_operation == OP_DIV) ? i_b_denominator : i_b_numerator;
                        r_bd <= (i_operation == OP_DIV) ? i_b_numerator : i_b_denominator;
                        r_res_sign <= 1'b0;
                        r_res_num  <= '0;
                        r_res_den  <= '0;
                        r_cmp  <= CMP_EQ;
                        r_zero <= 1'b0;
                        r_st   <= ST_OK;
                        r_ma <= i_a_numerator;
                        r_mb <= (i_operation == OP_MUL) ? i_b_numerator : i_b_denominator;
                        r_state <= S_MUL1;
                    end
                end
                S_MUL1: begin
                    // p = an*bd (or an*bn for mul/div)
                    r_p  <= w_prod;
                    r_ma <= r_ad;
                    r_mb <= r_bn;
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_q  <= w_prod;
                    r_ma <= r_ad;
                    r_mb <= r_bd;
                    r_state <= S_MUL3;
                end
                S_MUL3: begin
                    r_d <= w_prod;
                    r_state <= S_FORM;
                end
                S_FORM: begin
                    r_state <= S_DSET;
                    case (r_op)
                        OP_ADD, OP_SUB: begin
                            if (r_as == r_bs) begin
                                r_n <= t_num'(r_p) + t_num'(r_q);
                                r_sign <= r_as;
                            end else if (r_p > r_q) begin
                                r_n <= t_num'(r_p - r_q);
                                r_sign <= r_as;
                            end else begin
                                r_n <= t_num'(r_q - r_p);
                                r_sign <= r_bs;
                            end
                        end
                        OP_MUL, OP_DIV: begin
                            r_n <= t_num'(r_p);
                            r_sign <= r_as ^ r_bs;
                        end
                        OP_RED: begin
                            r_n <= t_num'(r_an);
                            r_d <= t_dword'(r_ad);
                            r_sign <= r_as;
                        end
                        OP_CMP: begin
                            r_cmp <= (r_p > r_q) ? CMP_GT :
                                     ((r_p == r_q) ? CMP_EQ : CMP_LT);
                            r_state <= S_OUT;
                        end
                        OP_ZERO: begin
                            r_zero <= (r_an == 32'd0);
                            r_state <= S_OUT;
                        end
                        default: r_state <= S_OUT;
                    endcase
                end
                S_DSET: begin
                    if (r_d == '0) begin
                        r_st <= ST_ZDIV;
                        r_state <= S_OUT;
                    end else begin
                        r_dvd <= r_n;
                        r_dvs <= r_d;
                        r_rem <= '0;
                        r_quo <= '0;
                        r_cnt <= 7'd0;
                        r_sel <= P_REM;
                        r_state <= S_DIV1;
                    end
                end
                S_DIV1: begin
                    // one restoring step per cycle, 65 steps
                    r_rem <= w_ge ? w_sub : w_sh;
                    r_quo <= {r_quo[63:0], w_ge};
                    r_dvd <= {r_dvd[63:0], 1'b0};
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt == 7'd64) begin
                        r_state <= S_GCD;
                    end
                end
                S_GCD: begin
                    r_cnt <= 7'd0;
                    r_rem <= '0;
                    case (r_sel)
                        P_REM: begin
                            // after n mod d: x=d, y=rem
                            r_gx <= r_dvs;
                            r_gy <= r_rem;
                            r_sel <= P_EUCLID;
                            r_state <= S_DIV3;
                        end
                        P_EUCLID: begin
                            r_gx <= r_dvs;
                            r_gy <= r_rem;
                            r_state <= S_DIV3;
                        end
                        P_NUM: begin
                            r_numq <= r_quo;
                            r_dvd <= t_num'(r_d);
                            r_sel <= P_DEN;
                            r_state <= S_DIV1;
                        end
                        default: begin
                            r_state <= S_FIN;
                        end
                    endcase
                end
                S_DIV3: begin
                    if (r_gy == '0) begin
                        // gcd found in r_gx, divide n by it
                        r_dvs <= r_gx;
                        r_dvd <= r_n;
                        r_quo <= '0;
                        r_sel <= P_NUM;
                        r_state <= S_DIV1;
                    end else begin
                        r_dvd <= t_num'(r_gx);
                        r_dvs <= r_gy;
                        r_quo <= '0;
                        r_state <= S_DIV2;
                    end
                end
                S_DIV2: begin
                    r_gx <= r_gy;
                    r_state <= S_DIV1;
                end
                S_FIN: begin
                    if (r_numq[64] || (r_numq[63:0] > LIM) || (r_quo[63:0] > LIM)) begin
                        r_st <= ST_OVF;
                    end else begin
                        r_res_num  <= r_numq[31:0];
                        r_res_den  <= r_quo[31:0];
                        r_res_sign <= (r_numq[63:0] == '0) ? 1'b0 : r_sign;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    property p_ready_idle;
        @(posedge i_clk) disable iff (!i_rst_n) o_valid |-> !o_ready;
    endproperty
    a_ready_idle: assert property (p_ready_idle) else $error("ready while result pending");

    a_out_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready) |=> (r_state == S_IDLE)) else $error("no return to idle");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == S_MUL1)) else $error("accept did not start");

    a_ovf_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_OK)) |-> (o_result_numerator == 32'd0))
        else $error("status with nonzero result");
endmodule
`default_nettype wire
